@@ rtl/wildcard_pattern_matcher_assert.svh @@
// Assertion macros used by the verification checker of the pattern matcher.
`ifndef WILDCARD_PATTERN_MATCHER_ASSERT_SVH
`define WILDCARD_PATTERN_MATCHER_ASSERT_SVH

// Checked on every rising edge of aclk, and not while aresetn is low.
`define WPM_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Checked on every rising edge of aclk, reset included.
`define WPM_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) prop) else $error(msg);

`endif

@@ rtl/wpm_pkg.sv @@
package wpm_pkg;

    // Operation codes carried on s_operation.
    typedef enum logic [1:0] {
        OP_APPEND = 2'd0,
        OP_TEXT   = 2'd1,
        OP_FINISH = 2'd2
    } op_t;

    localparam logic [7:0] STAR_CHAR  = 8'h2A;
    localparam logic [7:0] ANY_CHAR   = 8'h3F;
    localparam logic [7:0] UPPER_A    = 8'h41;
    localparam logic [7:0] UPPER_Z    = 8'h5A;
    localparam logic [7:0] CASE_SHIFT = 8'h20;

    // Signals that one cell hands to its right-hand neighbor.
    typedef struct packed {
        logic head;    // set only on the fixed column in front of the first cell
        logic valid;   // this column holds a pattern character
        logic start;   // start-row bit of this column
        logic match;   // current match-row bit of this column
        logic ripple;  // next match-row bit, computed this cycle
    } wpm_link_t;

    // Command broadcast to every cell for the accepted transfer.
    typedef struct packed {
        logic       append;
        logic       text;
        logic       finish;
        logic       clear;
        logic [7:0] ch_fold;
        logic       is_star;
        logic       is_any;
    } wpm_cmd_t;

    function automatic logic [7:0] fold_case(input logic [7:0] c);
        logic [7:0] r;
        r = c;
        if (c >= UPPER_A && c <= UPPER_Z) begin
            r = c + CASE_SHIFT;
        end
        return r;
    endfunction

endpackage

@@ rtl/wpm_cell.sv @@
module wpm_cell (
    input  logic               aclk,
    input  logic               aresetn,
    input  wpm_pkg::wpm_cmd_t  cmd,
    input  wpm_pkg::wpm_link_t left,
    output wpm_pkg::wpm_link_t right
);
    import wpm_pkg::*;

    logic       valid_reg, valid_next;
    logic       start_reg, start_next;
    logic       match_reg, match_next;
    logic [7:0] pat_reg;
    logic       star_reg;
    logic       any_reg;
    logic       sel;
    logic       hit;
    logic       ripple;

    // This cell takes the appended character when it is the first free column.
    assign sel = cmd.clear ? left.head : (left.valid & ~valid_reg);
    assign hit = any_reg | (pat_reg == cmd.ch_fold);
    assign ripple = valid_reg & (star_reg ? (left.ripple | match_reg)
                                          : (hit & left.match));

    always_comb begin
        valid_next = valid_reg;
        start_next = start_reg;
        match_next = match_reg;
        if (cmd.append) begin
            valid_next = cmd.clear ? left.head : (valid_reg | sel);
            if (sel) begin
                start_next = cmd.is_star & left.start;
            end else if (cmd.clear) begin
                start_next = 1'b0;
            end
            match_next = start_next;
        end else if (cmd.text) begin
            match_next = ripple;
        end else if (cmd.finish) begin
            match_next = start_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            start_reg <= 1'b0;
            match_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
            start_reg <= start_next;
            match_reg <= match_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.append && sel) begin
            pat_reg  <= cmd.ch_fold;
            star_reg <= cmd.is_star;
            any_reg  <= cmd.is_any;
        end
    end

    assign right.head   = 1'b0;
    assign right.valid  = valid_reg;
    assign right.start  = start_reg;
    assign right.match  = match_reg;
    assign right.ripple = ripple;

endmodule

@@ rtl/wildcard_pattern_matcher.sv @@
// Latency: a finish transfer shows its result on the m_ channel in the next cycle.
// Throughput: one transfer per cycle of any operation, unless a result waits
// on m_ with m_ready low; text bytes ripple a prefix OR through the row of cells combinationally.
// Reset (aresetn low, synchronous): empty pattern, start row with only the
// leftmost column set, overflow cleared, no result pending.
module wildcard_pattern_matcher #(
    parameter int PATTERN_MAX = 32
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [1:0] s_operation,
    input  logic [7:0] s_char_value,
    output logic       m_valid,
    input  logic       m_ready,
    output logic       m_matched,
    output logic       m_pattern_overflow
);
    import wpm_pkg::*;

    // The pattern lives in a row of cells, one per pattern character. Cell k
    // holds column k of the match row and of the start row; column zero is the
    // fixed head in front of the row. A cell's valid bit tells that it holds a
    // character, so the valid bits form the pattern length as a thermometer code.
    // Match-row bits beyond the pattern length always stay zero.

    wpm_link_t links [0:PATTERN_MAX];
    wpm_cmd_t  cmd;

    logic s_xfer;
    logic pending_reg, pending_next;
    logic ovf_reg, ovf_next;
    logic match0_reg, match0_next;
    logic row_hit;

    logic m_valid_reg;
    logic m_matched_reg;
    logic m_pattern_overflow_reg;

    // The output register parts the two sides: a new transfer is taken while
    // a result is being handed over in the same cycle.
    assign s_ready = ~m_valid_reg | m_ready;
    assign s_xfer  = s_valid & s_ready;

    always_comb begin
        cmd         = '0;
        cmd.clear   = pending_reg;
        cmd.ch_fold = fold_case(s_char_value);
        cmd.is_star = (s_char_value == STAR_CHAR);
        cmd.is_any  = (s_char_value == ANY_CHAR);
        if (s_xfer) begin
            unique case (s_operation)
                OP_APPEND: cmd.append = 1'b1;
                OP_TEXT:   cmd.text   = 1'b1;
                OP_FINISH: cmd.finish = 1'b1;
                default:   ;
            endcase
        end
    end

    // The head column: always valid, start bit always set.
    assign links[0].head   = 1'b1;
    assign links[0].valid  = 1'b1;
    assign links[0].start  = 1'b1;
    assign links[0].match  = match0_reg;
    assign links[0].ripple = 1'b0;

    for (genvar k = 1; k <= PATTERN_MAX; k++) begin : g_cell
        wpm_cell u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .cmd     (cmd),
            .left    (links[k-1]),
            .right   (links[k])
        );
    end

    // The last valid column holds the whole-pattern match bit.
    always_comb begin
        row_hit = links[PATTERN_MAX].valid & links[PATTERN_MAX].match;
        for (int j = 0; j < PATTERN_MAX; j++) begin
            row_hit = row_hit |
                      (links[j].valid & ~links[j+1].valid & links[j].match);
        end
    end

    always_comb begin
        pending_next = pending_reg;
        ovf_next     = ovf_reg;
        match0_next  = match0_reg;
        if (cmd.append) begin
            pending_next = 1'b0;
            // With every cell in use, the character is dropped.
            ovf_next     = pending_reg ? 1'b0 : (ovf_reg | links[PATTERN_MAX].valid);
            match0_next  = 1'b1;
        end else if (cmd.text) begin
            match0_next  = 1'b0;
        end else if (cmd.finish) begin
            pending_next = 1'b1;
            match0_next  = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pending_reg <= 1'b1;
            ovf_reg     <= 1'b0;
            match0_reg  <= 1'b1;
            m_valid_reg <= 1'b0;
        end else begin
            pending_reg <= pending_next;
            ovf_reg     <= ovf_next;
            match0_reg  <= match0_next;
            if (cmd.finish) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // An overflowed pattern never reports a match.
    always_ff @(posedge aclk) begin
        if (cmd.finish) begin
            m_matched_reg          <= ~ovf_reg & row_hit;
            m_pattern_overflow_reg <= ovf_reg;
        end
    end

    assign m_valid            = m_valid_reg;
    assign m_matched          = m_matched_reg;
    assign m_pattern_overflow = m_pattern_overflow_reg;

endmodule

@@ rtl/wpm_checker.sv @@
`include "wildcard_pattern_matcher_assert.svh"

module wpm_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_valid,
    input logic       s_ready,
    input logic [1:0] s_operation,
    input logic       m_valid,
    input logic       m_ready,
    input logic       m_matched,
    input logic       m_pattern_overflow
);
    import wpm_pkg::*;

    `WPM_ASSERT(a_m_valid_hold, m_valid && !m_ready |=> m_valid, "result dropped before transfer")
    `WPM_ASSERT(a_ovf_no_match, m_valid && m_pattern_overflow |-> !m_matched, "overflow with match")
    `WPM_ASSERT(a_finish_result, s_valid && s_ready && s_operation == OP_FINISH |=> m_valid, "finish gave no result")
    `WPM_ASSERT(a_no_spurious, s_valid && s_ready && s_operation != OP_FINISH && !m_valid |=> !m_valid, "result without finish")
    `WPM_ASSERT_ALWAYS(a_reset_idle, !aresetn |=> !m_valid, "result pending after reset")

endmodule

bind wildcard_pattern_matcher wpm_checker u_wpm_checker (.*);

@@ bench/tb.sv @@
`timescale 1ns / 1ps

module tb;
    import wpm_pkg::*;

    localparam int PMAX         = 32;
    localparam int ITEM_TARGET  = 550;
    localparam int QUIET_ITEMS  = 70;
    localparam int HOLD_CYCLES  = 80;
    localparam int DRAIN_CYCLES = 16;
    localparam int CYCLE_LIMIT  = 200000;

    // One expected verdict per finish transfer.
    typedef struct packed {
        logic matched;
        logic overflow;
    } verdict_t;

    // Tracks the pattern, the start row and the live match row the same way the
    // block should, and queues the verdict that each finish must produce.
    class match_verdicts;
        logic [7:0]    pat [PMAX];
        int            pat_len;
        logic [PMAX:0] start_row;
        logic [PMAX:0] match_row;
        logic          overflow;
        logic          fresh_pattern;
        verdict_t      verdicts_due[$];
        int            mismatches;

        function new();
            pat_len       = 0;
            start_row     = '0;
            start_row[0]  = 1'b1;
            match_row     = start_row;
            overflow      = 1'b0;
            fresh_pattern = 1'b1;
            mismatches    = 0;
        endfunction

        static function logic [7:0] lower_ascii(logic [7:0] c);
            if (c >= "A" && c <= "Z") begin
                return c + 8'h20;
            end
            return c;
        endfunction

        function void take_transfer(op_t op, logic [7:0] ch);
            logic [PMAX:0] nxt;
            logic [7:0]    p;
            verdict_t      v;
            case (op)
                OP_APPEND: begin
                    if (fresh_pattern) begin
                        pat_len       = 0;
                        overflow      = 1'b0;
                        fresh_pattern = 1'b0;
                        start_row     = '0;
                        start_row[0]  = 1'b1;
                    end
                    if (pat_len < PMAX) begin
                        pat[pat_len] = ch;
                        pat_len++;
                        start_row[pat_len] = (ch == STAR_CHAR) ? start_row[pat_len-1] : 1'b0;
                    end else begin
                        overflow = 1'b1;
                    end
                    match_row = start_row;
                end
                OP_TEXT: begin
                    nxt = '0;
                    for (int j = 1; j <= pat_len; j++) begin
                        p = pat[j-1];
                        if (p == STAR_CHAR) begin
                            nxt[j] = nxt[j-1] | match_row[j];
                        end else if (p == ANY_CHAR || lower_ascii(p) == lower_ascii(ch)) begin
                            nxt[j] = match_row[j-1];
                        end
                    end
                    match_row = nxt;
                end
                OP_FINISH: begin
                    v.matched  = !overflow && match_row[pat_len];
                    v.overflow = overflow;
                    verdicts_due = {verdicts_due, v};
                    match_row     = start_row;
                    fresh_pattern = 1'b1;
                end
                default: ;
            endcase
        endfunction

        function void check_verdict(logic matched, logic ovf);
            verdict_t v;
            if (verdicts_due.size() == 0) begin
                $error("result with no finish outstanding: matched=%0b pattern_overflow=%0b",
                       matched, ovf);
                mismatches++;
                return;
            end
            v = verdicts_due.pop_front();
            if (matched !== v.matched) begin
                $error("matched: expected %0b, actual %0b", v.matched, matched);
                mismatches++;
            end
            if (ovf !== v.overflow) begin
                $error("pattern_overflow: expected %0b, actual %0b", v.overflow, ovf);
                mismatches++;
            end
        endfunction
    endclass

    logic       aclk = 1'b0;
    logic       aresetn;
    logic       s_valid;
    logic       s_ready;
    logic [1:0] s_operation;
    logic [7:0] s_char_value;
    logic       m_valid;
    logic       m_ready;
    logic       m_matched;
    logic       m_pattern_overflow;

    match_verdicts sb;

    // Idle rates in percent, changed per pattern group by the stimulus process.
    int tx_gap_pct   = 20;
    int rx_stall_pct = 20;
    // Set by the stimulus to ask the receiver for one long hold-off.
    bit hold_req     = 1'b0;
    int items_sent   = 0;
    int cycles       = 0;

    // Pattern currently loaded and the text being built against it.
    logic [7:0] pat_q[$];
    logic [7:0] txt_q[$];

    wildcard_pattern_matcher #(
        .PATTERN_MAX(PMAX)
    ) u_top (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_operation        (s_operation),
        .s_char_value       (s_char_value),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_matched          (m_matched),
        .m_pattern_overflow (m_pattern_overflow)
    );

    always begin
        aclk = 1'b0;
        #6;
        aclk = 1'b1;
        #6;
    end

    // The run never takes anywhere near this long when the block behaves; hitting
    // the limit means a transfer hung somewhere.
    always @(posedge aclk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("wildcard_pattern_matcher verification failed");
            $finish;
        end
    end

    // Both channels are observed at the rising edge, where the values read are
    // the ones from before the edge. The result is checked before the input is
    // noted: a finish never shows its verdict on the edge at which it is taken.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready) begin
                sb.check_verdict(m_matched, m_pattern_overflow);
            end
            if (s_valid && s_ready) begin
                sb.take_transfer(op_t'(s_operation), s_char_value);
            end
        end
    end

    // Result side. Ready changes only at the falling edge. Stalls come in short
    // random bursts at the current rate, and once the stimulus asks for it, in a
    // single long hold-off so that finishes pile up and the block has to push
    // back on its input.
    initial begin
        int hold_count;
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_req) begin
                m_ready <= 1'b0;
                hold_count = 0;
                while (hold_count < HOLD_CYCLES) begin
                    @(negedge aclk);
                    hold_count++;
                end
                hold_req = 1'b0;
            end else if ($urandom_range(0, 99) < rx_stall_pct) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 9)) @(negedge aclk);
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // Offers one transfer, possibly after a burst of idle cycles, and returns at
    // the falling edge after it has been taken. Valid is only lowered when a gap
    // follows, so back-to-back transfers keep it high throughout.
    task automatic push_item(op_t op, logic [7:0] ch);
        if ($urandom_range(0, 99) < tx_gap_pct) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(negedge aclk);
        end
        s_valid      <= 1'b1;
        s_operation  <= op;
        s_char_value <= ch;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        @(negedge aclk);
        items_sent++;
    endtask

    // A letter out of a small alphabet in either case, so that literals collide
    // often enough to give real matches; now and then any byte at all.
    function automatic logic [7:0] alpha_char();
        logic [7:0] c;
        if ($urandom_range(0, 7) == 0) begin
            return 8'($urandom_range(0, 255));
        end
        c = 8'("a" + $urandom_range(0, 2));
        return $urandom_range(0, 1) ? c : c - 8'h20;
    endfunction

    function automatic logic [7:0] glob_char();
        int r;
        r = $urandom_range(0, 9);
        if (r < 2) begin
            return STAR_CHAR;
        end else if (r == 2) begin
            return ANY_CHAR;
        end
        return alpha_char();
    endfunction

    // Letters are handed back in either case, since case must not matter.
    function automatic logic [7:0] other_case(logic [7:0] p);
        logic [7:0] folded;
        folded = p | 8'h20;
        if (folded >= "a" && folded <= "z" && $urandom_range(0, 1)) begin
            return p ^ 8'h20;
        end
        return p;
    endfunction

    // Most texts are built from the pattern so that they should match: a star
    // expands to zero to three bytes, a question mark to any byte. A share of
    // them is then damaged in one place, and some texts are plain random.
    task automatic make_text();
        int style;
        int k;
        txt_q.delete();
        style = $urandom_range(0, 9);
        if (style < 2) begin
            repeat ($urandom_range(0, 6)) txt_q = {txt_q, alpha_char()};
        end else begin
            foreach (pat_q[i]) begin
                if (pat_q[i] == STAR_CHAR) begin
                    repeat ($urandom_range(0, 3)) txt_q = {txt_q, alpha_char()};
                end else if (pat_q[i] == ANY_CHAR) begin
                    txt_q = {txt_q, 8'($urandom_range(0, 255))};
                end else begin
                    txt_q = {txt_q, other_case(pat_q[i])};
                end
            end
            if (style >= 8 && txt_q.size() > 0) begin
                k = $urandom_range(0, txt_q.size() - 1);
                if ($urandom_range(0, 1)) begin
                    txt_q[k] = 8'($urandom_range(0, 255));
                end else begin
                    txt_q.delete(k);
                end
            end
        end
    endtask

    initial begin
        int         plen;
        int         rounds;
        bit         pressure_done;
        logic [7:0] c;

        s_valid       = 1'b0;
        s_operation   = OP_APPEND;
        s_char_value  = 8'h00;
        aresetn       = 1'b0;
        pressure_done = 1'b0;
        sb            = new();

        repeat (8) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Right after reset the pattern is empty: it matches the empty text
        // only, and anything else fails.
        push_item(OP_FINISH, 8'h00);
        push_item(OP_TEXT, "x");
        push_item(OP_FINISH, 8'hFF);

        // Upper-case literal, a star that eats a zero byte, and a question mark
        // that eats an all-ones byte.
        push_item(OP_APPEND, "A");
        push_item(OP_APPEND, STAR_CHAR);
        push_item(OP_APPEND, ANY_CHAR);
        push_item(OP_TEXT, "a");
        push_item(OP_TEXT, 8'h00);
        push_item(OP_TEXT, 8'hFF);
        push_item(OP_FINISH, 8'h00);

        // A new pattern, then an append in the middle of the text: the byte
        // already fed is thrown away and the text starts over.
        push_item(OP_APPEND, "z");
        push_item(OP_TEXT, "Z");
        push_item(OP_APPEND, 8'h00);
        push_item(OP_TEXT, "z");
        push_item(OP_TEXT, 8'h00);
        push_item(OP_FINISH, 8'h00);

        // The kept pattern is used again without reloading.
        push_item(OP_TEXT, "Z");
        push_item(OP_TEXT, 8'h00);
        push_item(OP_FINISH, 8'h00);

        // Single literal at the top of the byte range.
        push_item(OP_APPEND, 8'hFF);
        push_item(OP_TEXT, 8'hFF);
        push_item(OP_FINISH, 8'h00);

        // Random part: load a pattern, then run one to four texts against it.
        // Patterns are mostly short; some run past the capacity so that the
        // overflow path gets exercised.
        while (items_sent < ITEM_TARGET) begin
            if (items_sent >= ITEM_TARGET - QUIET_ITEMS) begin
                tx_gap_pct   = 0;
                rx_stall_pct = 0;
            end else begin
                case ($urandom_range(0, 3))
                    0: tx_gap_pct = 0;
                    1: tx_gap_pct = 10;
                    2: tx_gap_pct = 30;
                    default: tx_gap_pct = 50;
                endcase
                case ($urandom_range(0, 3))
                    0: rx_stall_pct = 0;
                    1: rx_stall_pct = 10;
                    2: rx_stall_pct = 30;
                    default: rx_stall_pct = 50;
                endcase
            end

            // Once, hold the result side off for a long stretch while the
            // sender keeps offering text bytes and finishes back to back.
            if (!pressure_done && items_sent >= 250) begin
                pressure_done = 1'b1;
                tx_gap_pct    = 0;
                hold_req      = 1'b1;
                repeat (16) begin
                    push_item(OP_TEXT, alpha_char());
                    push_item(OP_FINISH, 8'($urandom_range(0, 255)));
                end
            end

            pat_q.delete();
            plen = ($urandom_range(0, 99) < 85) ? $urandom_range(1, 8)
                                                : $urandom_range(PMAX - 4, PMAX + 4);
            repeat (plen) begin
                c = glob_char();
                pat_q = {pat_q, c};
                push_item(OP_APPEND, c);
            end

            rounds = $urandom_range(1, 4);
            for (int r = 0; r < rounds; r++) begin
                make_text();
                foreach (txt_q[i]) begin
                    // Only in the first text is the pattern still open, so an
                    // append there extends it rather than starting a new one.
                    if (r == 0 && $urandom_range(0, 19) == 0) begin
                        c = glob_char();
                        pat_q = {pat_q, c};
                        push_item(OP_APPEND, c);
                    end
                    push_item(OP_TEXT, txt_q[i]);
                end
                push_item(OP_FINISH, 8'($urandom_range(0, 255)));
            end
        end

        s_valid <= 1'b0;

        // Let every outstanding verdict come back, then give the block a further
        // drain period in which a stray result would show up.
        while (sb.verdicts_due.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (sb.mismatches == 0) begin
            $display("wildcard_pattern_matcher verification clean");
        end else begin
            $display("wildcard_pattern_matcher verification failed");
        end
        $finish;
    end

endmodule
